### rtl/aqc_pkg.sv
// Shared types and constants for the accelerated quadrature counter.
// No dependencies; used by the interfaces, the lane, the merge stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aqc_pkg;

   localparam int LEVEL_W   = 2;   // encoders that have pins in a sample
   localparam int TIME_W    = 16;
   localparam int GAP_W     = 8;
   localparam int POS_W     = 12;
   localparam int PWM_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam int NUM_ENCODERS_DEF = 2;

   localparam logic [GAP_W-1:0] SLOW_GAP_RST  = 8'd5;
   localparam logic [GAP_W-1:0] MID_GAP_RST   = 8'd3;
   localparam logic [POS_W-1:0] SLOW_STEP_RST = 12'd1;
   localparam logic [POS_W-1:0] MID_STEP_RST  = 12'd5;
   localparam logic [POS_W-1:0] FAST_STEP_RST = 12'd10;
   localparam logic [POS_W-1:0] MAX_POS_RST   = 12'd4095;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOW_GAP  = 3'd0,
      CSR_MID_GAP   = 3'd1,
      CSR_SLOW_STEP = 3'd2,
      CSR_MID_STEP  = 3'd3,
      CSR_FAST_STEP = 3'd4,
      CSR_MAX_POS   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [GAP_W-1:0] slow_gap_ms;
      logic [GAP_W-1:0] mid_gap_ms;
      logic [POS_W-1:0] slow_step;
      logic [POS_W-1:0] mid_step;
      logic [POS_W-1:0] fast_step;
      logic [POS_W-1:0] max_position;
   } cfg_type;

   // what one lane reports to the next lane and to the merge stage
   typedef struct packed {
      logic             edge_seen;   // an edge in this lane or any lower lane
      logic [POS_W-1:0] position;    // position after this transaction
   } lane_status_type;

endpackage

`default_nettype wire

### rtl/aqc_req_if.sv
// Request and response channel interfaces (valid/ready) of the quadrature counter.
// Depends on aqc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface aqc_req_if;
   logic                            valid;
   logic                            ready;
   logic [aqc_pkg::LEVEL_W-1:0]     a_levels;
   logic [aqc_pkg::LEVEL_W-1:0]     b_levels;
   logic [aqc_pkg::TIME_W-1:0]      now_ms;
   logic                            clear;

   modport source (output valid, a_levels, b_levels, now_ms, clear, input ready);
   modport sink   (input valid, a_levels, b_levels, now_ms, clear, output ready);
endinterface

interface aqc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [aqc_pkg::POS_W-1:0]       position_0;
   logic [aqc_pkg::POS_W-1:0]       position_1;
   logic [aqc_pkg::PWM_W-1:0]       pwm_duty;

   modport source (output valid, position_0, position_1, pwm_duty, input ready);
   modport sink   (input valid, position_0, position_1, pwm_duty, output ready);
endinterface

`default_nettype wire

### rtl/accelerated_quadrature_counter_top.sv
// Top level of the accelerated quadrature counter: configuration registers,
// encoder lanes and merge stage. Depends on aqc_pkg, aqc_req_if, aqc_lane, aqc_merge.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req_chan carries one pin sample per transaction: A and B levels of each
//   encoder (bit i for encoder i), a wrapping millisecond timestamp and a
//   clear flag. rsp_chan returns one transaction per sample: both positions
//   and the PWM duty (eight times position 1).
//   csr_we/csr_index/csr_wdata write the gap thresholds, step sizes and the
//   position ceiling; write only while no sample is in flight. Unknown
//   indexes are ignored.
// Timing
//   One lane per encoder works on the sample in the accept cycle; lanes are
//   chained only by a one-bit "edge already seen" flag, so a lower encoder's
//   edge forces the fast step on higher ones. The response is registered:
//   it shows in the cycle after acceptance. Throughput is one sample per
//   cycle while responses are claimed, as lanes store positions on accept.
// Stall and reset
//   While a response waits unclaimed, req_chan.ready is low; it follows
//   rsp_chan.ready combinationally so a steady stream never bubbles.
//   Synchronous reset zeroes positions, stored levels and the last-edge time,
//   drops the response valid and loads the default configuration.

module accelerated_quadrature_counter_top #(
   parameter int NUM_ENCODERS = aqc_pkg::NUM_ENCODERS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   aqc_req_if.sink                               req_chan,
   aqc_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [aqc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [aqc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   aqc_pkg::cfg_type            cfg_ff;
   aqc_pkg::lane_status_type    lanes [NUM_ENCODERS];
   logic [aqc_pkg::POS_W-1:0]   base_step;
   logic                        fire;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_gap_ms  <= aqc_pkg::SLOW_GAP_RST;
         cfg_ff.mid_gap_ms   <= aqc_pkg::MID_GAP_RST;
         cfg_ff.slow_step    <= aqc_pkg::SLOW_STEP_RST;
         cfg_ff.mid_step     <= aqc_pkg::MID_STEP_RST;
         cfg_ff.fast_step    <= aqc_pkg::FAST_STEP_RST;
         cfg_ff.max_position <= aqc_pkg::MAX_POS_RST;
      end else if (csr_we) begin
         unique case (aqc_pkg::csr_index_type'(csr_index))
            aqc_pkg::CSR_SLOW_GAP:  cfg_ff.slow_gap_ms  <= csr_wdata[aqc_pkg::GAP_W-1:0];
            aqc_pkg::CSR_MID_GAP:   cfg_ff.mid_gap_ms   <= csr_wdata[aqc_pkg::GAP_W-1:0];
            aqc_pkg::CSR_SLOW_STEP: cfg_ff.slow_step    <= csr_wdata[aqc_pkg::POS_W-1:0];
            aqc_pkg::CSR_MID_STEP:  cfg_ff.mid_step     <= csr_wdata[aqc_pkg::POS_W-1:0];
            aqc_pkg::CSR_FAST_STEP: cfg_ff.fast_step    <= csr_wdata[aqc_pkg::POS_W-1:0];
            aqc_pkg::CSR_MAX_POS:   cfg_ff.max_position <= csr_wdata[aqc_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   // accept whenever the response register is empty or being drained
   assign req_chan.ready = !rsp_chan.valid || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;

   // lanes; encoders without pins in the sample see constant low levels
   for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
      logic a_lv, b_lv, prior;

      if (i < aqc_pkg::LEVEL_W) begin : g_pins
         assign a_lv = req_chan.a_levels[i];
         assign b_lv = req_chan.b_levels[i];
      end else begin : g_nopins
         assign a_lv = 1'b0;
         assign b_lv = 1'b0;
      end

      if (i == 0) begin : g_first
         assign prior = 1'b0;
      end else begin : g_chain
         assign prior = lanes[i-1].edge_seen;
      end

      aqc_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .fire       (fire),
         .a_level    (a_lv),
         .b_level    (b_lv),
         .clear      (req_chan.clear),
         .prior_edge (prior),
         .base_step  (base_step),
         .cfg        (cfg_ff),
         .status     (lanes[i])
      );
   end

   aqc_merge #(
      .NUM_ENCODERS (NUM_ENCODERS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .now_ms    (req_chan.now_ms),
      .cfg       (cfg_ff),
      .lanes     (lanes),
      .base_step (base_step),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/aqc_lane.sv
// One encoder lane: stored A/B levels and position, step, clamp and clear.
// Depends on aqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aqc_lane (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic                          a_level,
   input  wire logic                          b_level,
   input  wire logic                          clear,
   input  wire logic                          prior_edge,
   input  wire logic [aqc_pkg::POS_W-1:0]     base_step,
   input  wire aqc_pkg::cfg_type              cfg,
   output aqc_pkg::lane_status_type           status
);

   logic                        a_seen_ff, b_seen_ff;
   logic [aqc_pkg::POS_W-1:0]   position_ff, position_in;
   logic                        a_chg, b_chg;
   logic [aqc_pkg::POS_W-1:0]   a_step, b_step, pos_a, pos_b;
   logic [aqc_pkg::POS_W:0]     sum;

   always_comb begin
      a_chg = a_level ^ a_seen_ff;
      b_chg = b_level ^ b_seen_ff;
      // an edge earlier in this transaction makes the gap zero: fast step
      a_step = prior_edge ? cfg.fast_step : base_step;
      b_step = (prior_edge | a_chg) ? cfg.fast_step : base_step;

      sum = {1'b0, position_ff};
      if (a_chg && a_level && !b_seen_ff) begin
         sum = {1'b0, position_ff} + {1'b0, a_step};
      end

      pos_a = position_ff;
      if (a_chg) begin
         pos_a = (sum > {1'b0, cfg.max_position}) ? cfg.max_position
                                                  : sum[aqc_pkg::POS_W-1:0];
      end

      pos_b = pos_a;
      if (b_chg && b_level && !a_level) begin
         pos_b = (b_step > pos_a) ? '0 : pos_a - b_step;
      end

      position_in = clear ? '0 : pos_b;

      status.edge_seen = prior_edge | a_chg | b_chg;
      status.position  = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_seen_ff   <= 1'b0;
         b_seen_ff   <= 1'b0;
         position_ff <= '0;
      end else if (fire) begin
         a_seen_ff   <= a_level;
         b_seen_ff   <= b_level;
         position_ff <= position_in;
      end
   end

endmodule

`default_nettype wire

### rtl/aqc_merge.sv
// Merge stage: shared last-edge time, step selection by gap, response register.
// Depends on aqc_pkg and aqc_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module aqc_merge #(
   parameter int NUM_ENCODERS = aqc_pkg::NUM_ENCODERS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [aqc_pkg::TIME_W-1:0]    now_ms,
   input  wire aqc_pkg::cfg_type              cfg,
   input  wire aqc_pkg::lane_status_type      lanes [NUM_ENCODERS],
   output logic [aqc_pkg::POS_W-1:0]          base_step,
   aqc_rsp_if.source                          rsp
);

   logic [aqc_pkg::TIME_W-1:0]  last_edge_ff;
   logic [aqc_pkg::TIME_W-1:0]  gap;
   logic                        valid_ff;
   logic [aqc_pkg::POS_W-1:0]   pos0_ff, pos1_ff, pos1_in;

   always_comb begin
      gap = now_ms - last_edge_ff;   // wraps modulo 2^16
      if (gap > {{(aqc_pkg::TIME_W-aqc_pkg::GAP_W){1'b0}}, cfg.slow_gap_ms}) begin
         base_step = cfg.slow_step;
      end else if (gap > {{(aqc_pkg::TIME_W-aqc_pkg::GAP_W){1'b0}}, cfg.mid_gap_ms}) begin
         base_step = cfg.mid_step;
      end else begin
         base_step = cfg.fast_step;
      end
   end

   if (NUM_ENCODERS > 1) begin : g_pos1
      assign pos1_in = lanes[1].position;
   end else begin : g_no_pos1
      assign pos1_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (fire) begin
            valid_ff <= 1'b1;
            if (lanes[NUM_ENCODERS-1].edge_seen) begin
               last_edge_ff <= now_ms;
            end
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pos0_ff <= lanes[0].position;
         pos1_ff <= pos1_in;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.position_0 = pos0_ff;
   assign rsp.position_1 = pos1_ff;
   assign rsp.pwm_duty   = {pos1_ff, 3'b000};

endmodule

`default_nettype wire

### verif/accelerated_quadrature_counter_top_tb.sv
// Self-checking testbench for accelerated_quadrature_counter_top: pin samples in,
// position/PWM transactions out, checked against an in-bench prediction.
// Depends on aqc_pkg and the aqc_req_if / aqc_rsp_if interfaces of the RTL.
`timescale 1ns / 1ps

module accelerated_quadrature_counter_top_tb;

   localparam int NUM_ENC        = aqc_pkg::NUM_ENCODERS_DEF;
   localparam int RSP_LATENCY    = 1;      // response is registered once
   localparam int WATCHDOG_LIMIT = 2000;   // cycles without any handshake

   // register indexes the block does not decode; writes to them must be ignored
   localparam logic [aqc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [aqc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   typedef struct packed {
      logic [aqc_pkg::LEVEL_W-1:0] a_levels;
      logic [aqc_pkg::LEVEL_W-1:0] b_levels;
      logic [aqc_pkg::TIME_W-1:0]  now_ms;
      logic                        clear;
   } pin_sample_type;

   typedef struct packed {
      logic [aqc_pkg::POS_W-1:0] position_0;
      logic [aqc_pkg::POS_W-1:0] position_1;
      logic [aqc_pkg::PWM_W-1:0] pwm_duty;
   } position_report_type;

   // ------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the registers and encoder state,
   // predicts the report of every accepted sample and checks responses in order.
   // ------------------------------------------------------------------------
   class position_scoreboard;
      logic [aqc_pkg::GAP_W-1:0]  slow_gap_ms;
      logic [aqc_pkg::GAP_W-1:0]  mid_gap_ms;
      logic [aqc_pkg::POS_W-1:0]  slow_step;
      logic [aqc_pkg::POS_W-1:0]  mid_step;
      logic [aqc_pkg::POS_W-1:0]  fast_step;
      logic [aqc_pkg::POS_W-1:0]  max_position;
      logic [aqc_pkg::POS_W-1:0]  positions [NUM_ENC];
      logic                       a_seen [NUM_ENC];
      logic                       b_seen [NUM_ENC];
      logic [aqc_pkg::TIME_W-1:0] last_edge_ms;
      position_report_type        pending_reports [$];
      int                         mismatches;

      function new();
         slow_gap_ms  = aqc_pkg::SLOW_GAP_RST;
         mid_gap_ms   = aqc_pkg::MID_GAP_RST;
         slow_step    = aqc_pkg::SLOW_STEP_RST;
         mid_step     = aqc_pkg::MID_STEP_RST;
         fast_step    = aqc_pkg::FAST_STEP_RST;
         max_position = aqc_pkg::MAX_POS_RST;
         for (int i = 0; i < NUM_ENC; i++) begin
            positions[i] = '0;
            a_seen[i]    = 1'b0;
            b_seen[i]    = 1'b0;
         end
         last_edge_ms = '0;
         mismatches   = 0;
      endfunction

      function void write_register(input logic [aqc_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [aqc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            aqc_pkg::CSR_SLOW_GAP:  slow_gap_ms  = data[aqc_pkg::GAP_W-1:0];
            aqc_pkg::CSR_MID_GAP:   mid_gap_ms   = data[aqc_pkg::GAP_W-1:0];
            aqc_pkg::CSR_SLOW_STEP: slow_step    = data[aqc_pkg::POS_W-1:0];
            aqc_pkg::CSR_MID_STEP:  mid_step     = data[aqc_pkg::POS_W-1:0];
            aqc_pkg::CSR_FAST_STEP: fast_step    = data[aqc_pkg::POS_W-1:0];
            aqc_pkg::CSR_MAX_POS:   max_position = data[aqc_pkg::POS_W-1:0];
            default: ;
         endcase
      endfunction

      // gap since the last edge of any encoder, wrapping at 16 bits
      function logic [aqc_pkg::POS_W-1:0] step_for(input logic [aqc_pkg::TIME_W-1:0] now_ms);
         logic [aqc_pkg::TIME_W-1:0] gap;
         gap = now_ms - last_edge_ms;
         if (gap > slow_gap_ms)
            return slow_step;
         if (gap > mid_gap_ms)
            return mid_step;
         return fast_step;
      endfunction

      function void note_sample(input pin_sample_type s);
         int unsigned               pos;
         logic [aqc_pkg::POS_W-1:0] step;
         position_report_type       rep;
         for (int i = 0; i < NUM_ENC; i++) begin
            pos = positions[i];
            if (s.a_levels[i] != a_seen[i]) begin
               a_seen[i] = ~a_seen[i];
               if (a_seen[i] && !b_seen[i])
                  pos += step_for(s.now_ms);
               if (pos > max_position)
                  pos = max_position;
               last_edge_ms = s.now_ms;
            end
            // B is handled after A, so it sees the A level and edge time just written
            if (s.b_levels[i] != b_seen[i]) begin
               b_seen[i] = ~b_seen[i];
               if (b_seen[i] && !a_seen[i]) begin
                  step = step_for(s.now_ms);
                  pos  = (step > pos) ? 0 : pos - step;
               end
               last_edge_ms = s.now_ms;
            end
            positions[i] = pos[aqc_pkg::POS_W-1:0];
         end
         if (s.clear)
            for (int i = 0; i < NUM_ENC; i++)
               positions[i] = '0;
         rep.position_0 = positions[0];
         rep.position_1 = positions[1];
         rep.pwm_duty   = {positions[1], 3'b000};
         pending_reports.push_back(rep);
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_report(input position_report_type got);
         position_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected response pos0=%0d pos1=%0d pwm=%0d",
                                      got.position_0, got.position_1, got.pwm_duty));
            return;
         end
         want = pending_reports.pop_front();
         if (got.position_0 !== want.position_0)
            report_mismatch($sformatf("position_0 got %0d want %0d",
                                      got.position_0, want.position_0));
         if (got.position_1 !== want.position_1)
            report_mismatch($sformatf("position_1 got %0d want %0d",
                                      got.position_1, want.position_1));
         if (got.pwm_duty !== want.pwm_duty)
            report_mismatch($sformatf("pwm_duty got %0d want %0d",
                                      got.pwm_duty, want.pwm_duty));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, channels and the block under test
   // ------------------------------------------------------------------------
   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [aqc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [aqc_pkg::CSR_DATA_W-1:0] csr_wdata;

   aqc_req_if req_chan ();
   aqc_rsp_if rsp_chan ();

   accelerated_quadrature_counter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   position_scoreboard sb = new();

   // idling knobs, changed per phase of the stimulus
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // levels and timestamp of the last driven sample; the random generator
   // walks the quadrature cycle from here
   logic [aqc_pkg::LEVEL_W-1:0] driven_a = '0;
   logic [aqc_pkg::LEVEL_W-1:0] driven_b = '0;
   logic [aqc_pkg::TIME_W-1:0]  last_sample_ms = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: ready is redrawn every cycle, so stalls land on every
   // phase of a response, including the cycle right after acceptance.
   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   // Monitor: values read here are the pre-edge ones, so a transaction is
   // seen exactly at the edge that accepts it. A response at this edge
   // always belongs to an earlier sample, so noting the sample first is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_sample({req_chan.a_levels, req_chan.b_levels,
                            req_chan.now_ms, req_chan.clear});
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_report({rsp_chan.position_0, rsp_chan.position_1,
                             rsp_chan.pwm_duty});
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver tasks. All of them are entered and left right at a rising edge.
   // ------------------------------------------------------------------------

   // Offer one sample and hold it until the block takes it.
   task automatic send_sample(input logic [aqc_pkg::LEVEL_W-1:0] a,
                              input logic [aqc_pkg::LEVEL_W-1:0] b,
                              input logic [aqc_pkg::TIME_W-1:0] now_ms, input logic clr);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.a_levels <= a;
      req_chan.b_levels <= b;
      req_chan.now_ms   <= now_ms;
      req_chan.clear    <= clr;
      driven_a       = a;
      driven_b       = b;
      last_sample_ms = now_ms;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Stop sending and wait for every predicted response. The first edge lets
   // the monitor note a sample accepted at the edge we were called on.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_register(input logic [aqc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [aqc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_register(idx, data);
   endtask

   // Write all six registers plus two undecoded indexes; block must be idle.
   task automatic program_config(input aqc_pkg::cfg_type cfg);
      repeat (RSP_LATENCY + 1) @(posedge clock);
      write_register(aqc_pkg::CSR_SLOW_GAP,  aqc_pkg::CSR_DATA_W'(cfg.slow_gap_ms));
      write_register(aqc_pkg::CSR_MID_GAP,   aqc_pkg::CSR_DATA_W'(cfg.mid_gap_ms));
      write_register(aqc_pkg::CSR_SLOW_STEP, cfg.slow_step);
      write_register(aqc_pkg::CSR_MID_STEP,  cfg.mid_step);
      write_register(aqc_pkg::CSR_FAST_STEP, cfg.fast_step);
      write_register(aqc_pkg::CSR_MAX_POS,   cfg.max_position);
      write_register(CSR_UNMAPPED_LO, aqc_pkg::CSR_DATA_W'($urandom));
      write_register(CSR_UNMAPPED_HI, aqc_pkg::CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic aqc_pkg::cfg_type random_config();
      aqc_pkg::cfg_type cfg;
      cfg.slow_gap_ms  = aqc_pkg::GAP_W'($urandom_range(0, 255));
      cfg.mid_gap_ms   = aqc_pkg::GAP_W'($urandom_range(0, 255));
      cfg.slow_step    = aqc_pkg::POS_W'($urandom_range(0, 40));
      cfg.mid_step     = aqc_pkg::POS_W'($urandom_range(0, 400));
      cfg.fast_step    = aqc_pkg::POS_W'($urandom_range(0, 4095));
      // small ceilings make the upper clamp common
      cfg.max_position = ($urandom_range(0, 1)) ? aqc_pkg::POS_W'($urandom_range(0, 300))
                                                : aqc_pkg::POS_W'($urandom_range(0, 4095));
      return cfg;
   endfunction

   // Random samples. Most are legal quadrature steps with a per-encoder
   // direction bias, so positions drift toward both clamps; the rest hold
   // still or jump to arbitrary levels (one or both pins may change at once).
   task automatic send_random(input int count);
      logic [aqc_pkg::LEVEL_W-1:0] a, b;
      logic [aqc_pkg::TIME_W-1:0]  now_ms;
      logic                        clr;
      int                          roll;
      int                          quad;
      int                          cw_pct [NUM_ENC];
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0)
            for (int e = 0; e < NUM_ENC; e++)
               cw_pct[e] = $urandom_range(0, 1) ? 80 : 20;
         a = driven_a;
         b = driven_b;
         for (int e = 0; e < NUM_ENC; e++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               a[e] = 1'($urandom_range(0, 1));
               b[e] = 1'($urandom_range(0, 1));
            end else if (roll >= 20) begin
               // quadrature order of (A,B): 00 -> 10 -> 11 -> 01 -> 00
               quad = driven_a[e] ? (driven_b[e] ? 2 : 1) : (driven_b[e] ? 3 : 0);
               quad = ($urandom_range(0, 99) < cw_pct[e]) ? (quad + 1) % 4 : (quad + 3) % 4;
               a[e] = (quad == 1 || quad == 2);
               b[e] = (quad >= 2);
            end
         end
         // mostly short gaps around the thresholds, sometimes long ones,
         // now and then an arbitrary jump that also exercises the wrap
         roll = $urandom_range(0, 99);
         if (roll < 55)
            now_ms = last_sample_ms + aqc_pkg::TIME_W'($urandom_range(0, 4));
         else if (roll < 80)
            now_ms = last_sample_ms + aqc_pkg::TIME_W'($urandom_range(0, 12));
         else if (roll < 95)
            now_ms = last_sample_ms + aqc_pkg::TIME_W'($urandom_range(0, 300));
         else
            now_ms = aqc_pkg::TIME_W'($urandom_range(0, 65535));
         clr = ($urandom_range(0, 99) < 3);
         // sender holds off until everything in flight has drained
         if (n == count / 2 || $urandom_range(0, 99) == 0)
            wait_until_drained();
         send_sample(a, b, now_ms, clr);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: directed samples first, then random phases under different
   // register settings and idling patterns. Every register change happens
   // with nothing in flight.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.a_levels <= '0;
      req_chan.b_levels <= '0;
      req_chan.now_ms   <= '0;
      req_chan.clear    <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // phase 0: reset settings, no idling
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_sample(2'b00, 2'b00, 16'd0,     1'b0);   // no edge at all
      send_sample(2'b01, 2'b00, 16'd200,   1'b0);   // enc0 A rises, long gap: slow step
      send_sample(2'b11, 2'b00, 16'd204,   1'b0);   // enc1 A rises, gap 4: mid step
      send_sample(2'b11, 2'b10, 16'd205,   1'b0);   // enc1 B rises with A high: no step
      send_sample(2'b10, 2'b10, 16'd206,   1'b0);   // enc0 A falls: clamp only
      send_sample(2'b10, 2'b11, 16'd207,   1'b0);   // enc0 B rises, A low: underflow
      send_sample(2'b00, 2'b00, 16'd65535, 1'b0);   // enc0 B, enc1 A and enc1 B fall, top of time
      send_sample(2'b00, 2'b10, 16'd2,     1'b0);   // enc1 down across the time wrap
      send_sample(2'b01, 2'b00, 16'd10,    1'b0);   // enc0 up and enc1 B falls together
      send_sample(2'b00, 2'b01, 16'd11,    1'b0);   // enc0 A falls and B rises together
      send_sample(2'b11, 2'b11, 16'd65535, 1'b1);   // all fields at their maximum
      send_sample(2'b00, 2'b00, 16'd0,     1'b0);
      send_sample(2'b10, 2'b00, 16'd100,   1'b0);   // enc1 up again
      send_sample(2'b10, 2'b00, 16'd100,   1'b1);   // clear without any edge
      send_random(150);

      // phase 1: every register at its maximum; A rises overflow the clamp
      wait_until_drained();
      program_config('{slow_gap_ms: 8'd255, mid_gap_ms: 8'd255, slow_step: 12'd4095,
                       mid_step: 12'd4095, fast_step: 12'd4095, max_position: 12'd4095});
      sender_idle_pct = 71;
      send_sample(2'b00, 2'b00, last_sample_ms + 16'd1, 1'b0);
      send_sample(2'b01, 2'b00, last_sample_ms + 16'd1, 1'b0);
      send_sample(2'b00, 2'b00, last_sample_ms + 16'd1, 1'b0);
      send_sample(2'b11, 2'b00, last_sample_ms + 16'd1, 1'b0);  // enc0 overflows
      send_sample(2'b00, 2'b00, last_sample_ms + 16'd1, 1'b0);

      // phase 2: ceiling lowered under the positions. B level changes leave them
      // above the new ceiling until the next A change pulls them down.
      wait_until_drained();
      program_config('{slow_gap_ms: 8'd20, mid_gap_ms: 8'd10, slow_step: 12'd1,
                       mid_step: 12'd2, fast_step: 12'd3, max_position: 12'd100});
      send_sample(2'b00, 2'b01, last_sample_ms + 16'd1, 1'b0);
      send_sample(2'b00, 2'b11, last_sample_ms + 16'd1, 1'b0);
      send_sample(2'b01, 2'b11, last_sample_ms + 16'd1, 1'b0);
      send_sample(2'b11, 2'b11, last_sample_ms + 16'd1, 1'b0);
      send_random(200);

      // phase 3: every register at zero, receiver stalling
      wait_until_drained();
      program_config('0);
      sender_idle_pct    = 0;
      receiver_stall_pct = 71;
      send_random(100);

      // phase 4: random settings, both sides idling lightly
      wait_until_drained();
      program_config(random_config());
      sender_idle_pct    = 18;
      receiver_stall_pct = 18;
      send_random(200);

      // phase 5: any nonzero gap takes the large slow step
      wait_until_drained();
      program_config('{slow_gap_ms: 8'd0, mid_gap_ms: 8'd255, slow_step: 12'd4095,
                       mid_step: 12'd1, fast_step: 12'd2, max_position: 12'd4095});
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_random(150);

      // phase 6: random settings again, receiver stalling
      wait_until_drained();
      program_config(random_config());
      receiver_stall_pct = 71;
      send_random(100);

      // drain, then give a stray response time to show up
      wait_until_drained();
      repeat (RSP_LATENCY + 3) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
rtl/aqc_pkg.sv
rtl/aqc_req_if.sv
rtl/aqc_lane.sv
rtl/aqc_merge.sv
rtl/accelerated_quadrature_counter_top.sv
verif/accelerated_quadrature_counter_top_tb.sv
